// ===== rtl/zsm_pkg.sv =====
// Shared types and constants for the zero-skew merge point unit.
`default_nettype none
package zsm_pkg;

    localparam int SQ_STEPS  = 57;   // one root bit per cell
    localparam int DIV_STEPS = 30;   // one quotient bit per cell

    localparam logic [29:0] LEN_MAX = 30'h3FFF_FFFF;

    localparam logic [7:0] CFG_RES = 8'd0;
    localparam logic [7:0] CFG_CAP = 8'd1;

    typedef enum logic [1:0] {
        CASE_BAL   = 2'd0,
        CASE_EXT_B = 2'd1,
        CASE_EXT_A = 2'd2,
        CASE_ZERO  = 2'd3
    } t_case;

    // side data carried along the square root chain
    typedef struct packed {
        t_case        kind;
        logic [20:0]  d;
        logic [55:0]  rcl;
        logic [91:0]  num;
        logic [69:0]  den;
        logic [47:0]  rc;
    } t_sq_side;

    typedef struct packed {
        logic [113:0] n;     // radicand, consumed two bits per step from the top
        logic [57:0]  rem;
        logic [56:0]  root;
        t_sq_side     side;
    } t_sq_word;

    // side data carried along the divider chain
    typedef struct packed {
        t_case        kind;
        logic         sat;
        logic [20:0]  d;
    } t_dv_side;

    typedef struct packed {
        logic [69:0]  rem;   // partial remainder, below the divisor unless sat is set
        logic [69:0]  dvs;
        logic [29:0]  low;   // dividend bits still to bring down
        logic [29:0]  quot;
        t_dv_side     side;
    } t_dv_word;

endpackage
`default_nettype wire

// ===== rtl/zsm_sqrt_cell.sv =====
// One digit-by-digit integer square root step, registered.
`default_nettype none
module zsm_sqrt_cell
    import zsm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire logic     i_valid,
    input  wire t_sq_word i_word,
    output logic          o_valid,
    output t_sq_word      o_word
);

    logic     r_valid;
    t_sq_word r_word;
    t_sq_word n_word;
    logic [59:0] sh;
    logic [59:0] trial;
    logic        ge;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        sh     = {i_word.rem, i_word.n[113:112]};
        trial  = {1'b0, i_word.root, 2'b01};
        ge     = (sh >= trial);
        n_word = i_word;
        n_word.n    = {i_word.n[111:0], 2'b00};
        n_word.rem  = ge ? 58'(sh - trial) : sh[57:0];
        n_word.root = {i_word.root[55:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== rtl/zsm_div_cell.sv =====
// One restoring division step, registered.
`default_nettype none
module zsm_div_cell
    import zsm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire logic     i_valid,
    input  wire t_dv_word i_word,
    output logic          o_valid,
    output t_dv_word      o_word
);

    logic     r_valid;
    t_dv_word r_word;
    t_dv_word n_word;
    logic [70:0] sh;
    logic        ge;

    // shift in one dividend bit, subtract divisor if it fits
    always_comb begin
        sh     = {i_word.rem, i_word.low[29]};
        ge     = (sh >= {1'b0, i_word.dvs});
        n_word = i_word;
        n_word.rem  = ge ? 70'(sh - {1'b0, i_word.dvs}) : sh[69:0];
        n_word.low  = {i_word.low[28:0], 1'b0};
        n_word.quot = {i_word.quot[28:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
`default_nettype wire

// ===== rtl/zero_skew_merge_point_unit.sv =====
// Top level: zero-skew tapping point and snaked wire lengths for two subtrees.
// Pipeline: 9 front stages, 57 square root cells, 1 divider setup stage,
// 30 divider cells and 1 output register.
// Throughput: one word per cycle; the whole pipeline stalls only while the
// output register holds a word that is not taken.
// Reset clears all valid bits and loads r = c = 1.0; no clearing pass.
`default_nettype none
module zero_skew_merge_point_unit
    import zsm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // a_x, a_y, b_x, b_y (20 each), a_delay, b_delay (40 each), a_load, b_load (32 each)
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [223:0] i_s_tdata,
    // length_a (30), length_b (30), zero fill (4)
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata,
    // merge_case (2)
    output logic [1:0]        o_m_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [23:0]  i_cfg_data
);

    logic adv;
    logic [23:0] r_res, r_cap;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 24'd65536;
            r_cap <= 24'd65536;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RES) r_res <= i_cfg_data;
            if (i_cfg_index == CFG_CAP) r_cap <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    logic r_out_valid;
    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv;

    // input unpacking
    logic [19:0] ax, ay, bx, by, dx, dy;
    assign ax = i_s_tdata[19:0];
    assign ay = i_s_tdata[39:20];
    assign bx = i_s_tdata[59:40];
    assign by = i_s_tdata[79:60];
    assign dx = (ax >= bx) ? ax - bx : bx - ax;
    assign dy = (ay >= by) ? ay - by : by - ay;

    logic [8:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[7:0], i_s_tvalid};
        end
    end

    // stage 1: distance, r*c
    logic [20:0] r1_d;
    logic [39:0] r1_ta, r1_tb;
    logic [31:0] r1_ca, r1_cb;
    logic [47:0] r1_rc;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_d  <= {1'b0, dx} + {1'b0, dy};
            r1_ta <= i_s_tdata[119:80];
            r1_tb <= i_s_tdata[159:120];
            r1_ca <= i_s_tdata[191:160];
            r1_cb <= i_s_tdata[223:192];
            r1_rc <= r_res * r_cap;
        end
    end

    // stage 2: c*d, r*d, r*loads
    logic [20:0] r2_d;
    logic [39:0] r2_ta, r2_tb;
    logic [31:0] r2_ca, r2_cb;
    logic [47:0] r2_rc;
    logic [44:0] r2_cd, r2_rd;
    logic [55:0] r2_rcla, r2_rclb;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_d    <= r1_d;
            r2_ta   <= r1_ta;
            r2_tb   <= r1_tb;
            r2_ca   <= r1_ca;
            r2_cb   <= r1_cb;
            r2_rc   <= r1_rc;
            r2_cd   <= r_cap * r1_d;
            r2_rd   <= r_res * r1_d;
            r2_rcla <= r_res * r1_ca;
            r2_rclb <= r_res * r1_cb;
        end
    end

    // stage 3: capacitance sum, s, halves of r*d*s
    logic [32:0] csum;
    logic [45:0] capsum, s_val;
    assign csum   = {1'b0, r2_ca} + {1'b0, r2_cb};
    assign capsum = {5'b0, csum, 8'b0} + {1'b0, r2_cd};
    assign s_val  = {5'b0, r2_cb, 9'b0} + {1'b0, r2_cd};

    logic [20:0] r3_d;
    logic [39:0] r3_ta, r3_tb;
    logic [47:0] r3_rc;
    logic [55:0] r3_rcla, r3_rclb;
    logic [45:0] r3_capsum;
    logic [67:0] r3_pl, r3_ph;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_d      <= r2_d;
            r3_ta     <= r2_ta;
            r3_tb     <= r2_tb;
            r3_rc     <= r2_rc;
            r3_rcla   <= r2_rcla;
            r3_rclb   <= r2_rclb;
            r3_capsum <= capsum;
            r3_pl     <= r2_rd * s_val[22:0];
            r3_ph     <= r2_rd * s_val[45:23];
        end
    end

    // stage 4: denominator, r*d*s
    logic [20:0] r4_d;
    logic [39:0] r4_ta, r4_tb;
    logic [47:0] r4_rc;
    logic [55:0] r4_rcla, r4_rclb;
    logic [69:0] r4_den;
    logic [90:0] r4_rds;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_d    <= r3_d;
            r4_ta   <= r3_ta;
            r4_tb   <= r3_tb;
            r4_rc   <= r3_rc;
            r4_rcla <= r3_rcla;
            r4_rclb <= r3_rclb;
            r4_den  <= r_res * r3_capsum;
            r4_rds  <= {23'b0, r3_pl} + {r3_ph, 23'b0};
        end
    end

    // stage 5: p, q, halves of den*2d
    logic [21:0] d2;
    assign d2 = {r4_d, 1'b0};
    logic [20:0] r5_d;
    logic [39:0] r5_ta, r5_tb;
    logic [47:0] r5_rc;
    logic [55:0] r5_rcla, r5_rclb;
    logic [69:0] r5_den;
    logic        r5_dzero;
    logic [91:0] r5_p;
    logic [64:0] r5_q;
    logic [56:0] r5_dl, r5_dh;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_d     <= r4_d;
            r5_ta    <= r4_ta;
            r5_tb    <= r4_tb;
            r5_rc    <= r4_rc;
            r5_rcla  <= r4_rcla;
            r5_rclb  <= r4_rclb;
            r5_den   <= r4_den;
            r5_dzero <= (r4_den == '0);
            r5_p     <= {27'b0, r4_tb, 25'b0} + {1'b0, r4_rds};
            r5_q     <= {r4_ta, 25'b0};
            r5_dl    <= r4_den[34:0] * d2;
            r5_dh    <= r4_den[69:35] * d2;
        end
    end

    // stage 6: numerator and balance limit
    logic [20:0] r6_d;
    logic [39:0] r6_ta, r6_tb;
    logic [47:0] r6_rc;
    logic [55:0] r6_rcla, r6_rclb;
    logic [69:0] r6_den;
    logic        r6_dzero, r6_lt;
    logic [91:0] r6_num, r6_m;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_d     <= r5_d;
            r6_ta    <= r5_ta;
            r6_tb    <= r5_tb;
            r6_rc    <= r5_rc;
            r6_rcla  <= r5_rcla;
            r6_rclb  <= r5_rclb;
            r6_den   <= r5_den;
            r6_dzero <= r5_dzero;
            r6_lt    <= (r5_p < {27'b0, r5_q});
            r6_num   <= r5_p - {27'b0, r5_q};
            r6_m     <= {35'b0, r5_dl} + {r5_dh, 35'b0};
        end
    end

    // stage 7: pick the case and the snaking operands
    t_case       k7;
    logic [55:0] rcl7;
    logic [39:0] dt7;
    always_comb begin
        k7   = CASE_ZERO;
        rcl7 = r6_rclb;
        dt7  = r6_ta - r6_tb;
        priority if (r6_dzero) begin
            k7 = CASE_ZERO;
        end else if (r6_lt) begin
            k7 = (r6_rc == '0) ? CASE_ZERO : CASE_EXT_B;
        end else if (r6_num <= r6_m) begin
            k7 = CASE_BAL;
        end else begin
            k7   = (r6_rc == '0) ? CASE_ZERO : CASE_EXT_A;
            rcl7 = r6_rcla;
            dt7  = (r6_tb >= r6_ta) ? r6_tb - r6_ta : '0;
        end
    end

    t_sq_side    r7_side;
    logic [39:0] r7_dt;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_side.kind <= k7;
            r7_side.d    <= r6_d;
            r7_side.rcl  <= rcl7;
            r7_side.num  <= r6_num;
            r7_side.den  <= r6_den;
            r7_side.rc   <= r6_rc;
            r7_dt        <= dt7;
        end
    end

    // stage 8: partial products of (r*cl)^2 and r*c*dt
    t_sq_side    r8_side;
    logic [55:0] r8_hh, r8_hl, r8_ll;
    logic [67:0] r8_pd0, r8_pd1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_side <= r7_side;
            r8_hh   <= r7_side.rcl[55:28] * r7_side.rcl[55:28];
            r8_hl   <= r7_side.rcl[55:28] * r7_side.rcl[27:0];
            r8_ll   <= r7_side.rcl[27:0] * r7_side.rcl[27:0];
            r8_pd0  <= r7_side.rc * r7_dt[19:0];
            r8_pd1  <= r7_side.rc * r7_dt[39:20];
        end
    end

    // stage 9: radicand
    t_sq_word r9_word;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_word.side <= r8_side;
            r9_word.rem  <= '0;
            r9_word.root <= '0;
            r9_word.n    <= {2'b0, r8_hh, 56'b0} + {29'b0, r8_hl, 29'b0}
                          + {58'b0, r8_ll} + {17'b0, r8_pd1, 29'b0}
                          + {37'b0, r8_pd0, 9'b0};
        end
    end

    // square root chain
    logic     sq_v [0:SQ_STEPS];
    t_sq_word sq_w [0:SQ_STEPS];
    assign sq_v[0] = r_v[8];
    assign sq_w[0] = r9_word;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        zsm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (sq_v[g]),
            .i_word  (sq_w[g]),
            .o_valid (sq_v[g+1]),
            .o_word  (sq_w[g+1])
        );
    end

    // divider setup: balanced tapping point or snaking quotient
    t_sq_word    sq_o;
    logic [56:0] diff;
    t_dv_word    dv_in;
    assign sq_o = sq_w[SQ_STEPS];
    assign diff = (sq_o.root >= {1'b0, sq_o.side.rcl})
                ? sq_o.root - {1'b0, sq_o.side.rcl} : '0;

    always_comb begin
        dv_in.side.kind = sq_o.side.kind;
        dv_in.side.d    = sq_o.side.d;
        dv_in.quot      = '0;
        if (sq_o.side.kind == CASE_BAL) begin
            dv_in.rem      = {1'b0, sq_o.side.num[91:23]};
            dv_in.dvs      = sq_o.side.den;
            dv_in.low      = {sq_o.side.num[22:0], 7'b0};
            dv_in.side.sat = 1'b0;
        end else begin
            dv_in.rem      = {27'b0, diff[56:14]};
            dv_in.dvs      = {22'b0, sq_o.side.rc};
            dv_in.low      = {diff[13:0], 16'b0};
            dv_in.side.sat = ({5'b0, diff[56:14]} >= sq_o.side.rc);
        end
    end

    logic     r10_valid;
    t_dv_word r10_word;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_valid <= 1'b0;
        end else if (adv) begin
            r10_valid <= sq_v[SQ_STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r10_word <= dv_in;
        end
    end

    // divider chain
    logic     dv_v [0:DIV_STEPS];
    t_dv_word dv_w [0:DIV_STEPS];
    assign dv_v[0] = r10_valid;
    assign dv_w[0] = r10_word;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_dv
        zsm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (dv_v[g]),
            .i_word  (dv_w[g]),
            .o_valid (dv_v[g+1]),
            .o_word  (dv_w[g+1])
        );
    end

    // final lengths
    t_dv_word    dv_o;
    logic [29:0] len_a, len_b, snk;
    assign dv_o = dv_w[DIV_STEPS];
    assign snk  = dv_o.side.sat ? LEN_MAX : dv_o.quot;

    always_comb begin
        unique case (dv_o.side.kind)
            CASE_BAL: begin
                len_a = dv_o.quot;
                len_b = {1'b0, dv_o.side.d, 8'b0} - dv_o.quot;
            end
            CASE_EXT_B: begin
                len_a = '0;
                len_b = snk;
            end
            CASE_EXT_A: begin
                len_a = snk;
                len_b = '0;
            end
            CASE_ZERO: begin
                len_a = '0;
                len_b = '0;
            end
        endcase
    end

    // output register
    logic [29:0] r_len_a, r_len_b;
    t_case       r_kind;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dv_v[DIV_STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_len_a <= len_a;
            r_len_b <= len_b;
            r_kind  <= dv_o.side.kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_len_b, r_len_a};
    assign o_m_tuser  = r_kind;

    // checks
    a_zero_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == CASE_ZERO) |-> (r_len_a == '0 && r_len_b == '0))
        else $error("zero divisor word with nonzero lengths");
    a_ext_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == CASE_EXT_B) |-> (r_len_a == '0))
        else $error("B extended but A length nonzero");
    a_ext_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == CASE_EXT_A) |-> (r_len_b == '0))
        else $error("A extended but B length nonzero");
    a_bal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == CASE_BAL) |-> (r_len_a[29] == 1'b0 && r_len_b[29] == 1'b0))
        else $error("balanced length out of range");

endmodule
`default_nettype wire
